FILE: rtl/core/ptrot_pkg.sv
// Package for the point rotation block: sine/cosine table and angle constants.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ptrot_pkg;

    localparam int ANGLE_BITS = 10;
    localparam int TABLE_FRAC = 14;
    localparam int TABLE_BITS = 15;
    localparam int INDEX_BITS = 6;
    localparam int FOLD_BITS  = 9;

    localparam logic signed [ANGLE_BITS-1:0] ANGLE_LAST = 10'sd359;
    localparam logic [FOLD_BITS-1:0] ANG_360 = 9'd360;
    localparam logic [FOLD_BITS-1:0] ANG_180 = 9'd180;
    localparam logic [FOLD_BITS-1:0] ANG_90  = 9'd90;
    localparam logic [FOLD_BITS-1:0] ANG_45  = 9'd45;

    // Octant fold of one angle
    typedef struct packed {
        logic                  err;
        logic                  neg_s;
        logic                  neg_c;
        logic                  swap;
        logic [INDEX_BITS-1:0] idx;
    } fold_t;

    function automatic logic [TABLE_BITS-1:0] cos_q14(input logic [INDEX_BITS-1:0] idx);
        logic [TABLE_BITS-1:0] v;
        case (idx)
            6'd0:  v = 15'd16384;  6'd1:  v = 15'd16382;  6'd2:  v = 15'd16374;
            6'd3:  v = 15'd16362;  6'd4:  v = 15'd16344;  6'd5:  v = 15'd16322;
            6'd6:  v = 15'd16294;  6'd7:  v = 15'd16262;  6'd8:  v = 15'd16225;
            6'd9:  v = 15'd16182;  6'd10: v = 15'd16135;  6'd11: v = 15'd16083;
            6'd12: v = 15'd16026;  6'd13: v = 15'd15964;  6'd14: v = 15'd15897;
            6'd15: v = 15'd15826;  6'd16: v = 15'd15749;  6'd17: v = 15'd15668;
            6'd18: v = 15'd15582;  6'd19: v = 15'd15491;  6'd20: v = 15'd15396;
            6'd21: v = 15'd15296;  6'd22: v = 15'd15191;  6'd23: v = 15'd15082;
            6'd24: v = 15'd14968;  6'd25: v = 15'd14849;  6'd26: v = 15'd14726;
            6'd27: v = 15'd14598;  6'd28: v = 15'd14466;  6'd29: v = 15'd14330;
            6'd30: v = 15'd14189;  6'd31: v = 15'd14044;  6'd32: v = 15'd13894;
            6'd33: v = 15'd13741;  6'd34: v = 15'd13583;  6'd35: v = 15'd13421;
            6'd36: v = 15'd13255;  6'd37: v = 15'd13085;  6'd38: v = 15'd12911;
            6'd39: v = 15'd12733;  6'd40: v = 15'd12551;  6'd41: v = 15'd12365;
            6'd42: v = 15'd12176;  6'd43: v = 15'd11982;  6'd44: v = 15'd11786;
            6'd45: v = 15'd11585;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [TABLE_BITS-1:0] sin_q14(input logic [INDEX_BITS-1:0] idx);
        logic [TABLE_BITS-1:0] v;
        case (idx)
            6'd0:  v = 15'd0;      6'd1:  v = 15'd286;    6'd2:  v = 15'd572;
            6'd3:  v = 15'd857;    6'd4:  v = 15'd1143;   6'd5:  v = 15'd1428;
            6'd6:  v = 15'd1713;   6'd7:  v = 15'd1997;   6'd8:  v = 15'd2280;
            6'd9:  v = 15'd2563;   6'd10: v = 15'd2845;   6'd11: v = 15'd3126;
            6'd12: v = 15'd3406;   6'd13: v = 15'd3686;   6'd14: v = 15'd3964;
            6'd15: v = 15'd4240;   6'd16: v = 15'd4516;   6'd17: v = 15'd4790;
            6'd18: v = 15'd5063;   6'd19: v = 15'd5334;   6'd20: v = 15'd5604;
            6'd21: v = 15'd5872;   6'd22: v = 15'd6138;   6'd23: v = 15'd6402;
            6'd24: v = 15'd6664;   6'd25: v = 15'd6924;   6'd26: v = 15'd7182;
            6'd27: v = 15'd7438;   6'd28: v = 15'd7692;   6'd29: v = 15'd7943;
            6'd30: v = 15'd8192;   6'd31: v = 15'd8438;   6'd32: v = 15'd8682;
            6'd33: v = 15'd8923;   6'd34: v = 15'd9162;   6'd35: v = 15'd9397;
            6'd36: v = 15'd9630;   6'd37: v = 15'd9860;   6'd38: v = 15'd10087;
            6'd39: v = 15'd10311;  6'd40: v = 15'd10531;  6'd41: v = 15'd10749;
            6'd42: v = 15'd10963;  6'd43: v = 15'd11174;  6'd44: v = 15'd11381;
            6'd45: v = 15'd11585;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/point_rotate_by_degrees.sv
// Top level of the point rotation block: front end, queue and rotation pipeline.
// Depends on ptrot_pkg, ptrot_front, ptrot_queue and ptrot_back.
`timescale 1ns / 1ps
`default_nettype none

// Rotates a signed point by a whole-degree angle, one point per clock. A word is
// taken at each edge where start is high and busy is low; its result appears on
// x_out, y_out and angle_error for one cycle, marked by done, once the edge that
// took it has written the queue and the product stage, the sum stage and the
// output register have followed in that order. The receiver cannot stall: the
// pipeline drains the two-word queue every cycle, so busy stays low and a new word
// may follow every cycle. The four multipliers of the product stage set the clock
// rate. Angles outside 0..359 return the point unchanged with angle_error set.
// Results are truncated toward zero.
module point_rotate_by_degrees #(
    parameter int COORD_BITS     = 11,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    start,
    output logic                                         busy,
    input  wire logic signed [ptrot_pkg::ANGLE_BITS-1:0] angle,
    input  wire logic signed [COORD_BITS-1:0]            x_in,
    input  wire logic signed [COORD_BITS-1:0]            y_in,
    output logic                                         done,
    output logic signed [COORD_BITS:0]                   x_out,
    output logic signed [COORD_BITS:0]                   y_out,
    output logic                                         angle_error
);
    import ptrot_pkg::*;

    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int QW = 1 + 2 * TW + 2 * COORD_BITS;

    logic                          f_err;
    logic signed [TW-1:0]          f_cos;
    logic signed [TW-1:0]          f_sin;
    logic                          push;
    logic                          q_full;
    logic                          q_valid;
    logic [QW-1:0]                 q_in;
    logic [QW-1:0]                 q_out;

    ptrot_front #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_front (
        .angle   (angle),
        .err     (f_err),
        .cos_val (f_cos),
        .sin_val (f_sin)
    );

    assign busy = q_full;
    assign push = start & ~q_full;
    assign q_in = {f_err, f_cos, f_sin, x_in, y_in};

    ptrot_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_data  (q_out)
    );

    ptrot_back #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (q_valid),
        .in_err      (q_out[QW-1]),
        .in_cos      (q_out[QW-2 -: TW]),
        .in_sin      (q_out[QW-2-TW -: TW]),
        .in_x        (q_out[2*COORD_BITS-1 -: COORD_BITS]),
        .in_y        (q_out[COORD_BITS-1:0]),
        .done        (done),
        .x_out       (x_out),
        .y_out       (y_out),
        .angle_error (angle_error)
    );

endmodule

`default_nettype wire

FILE: rtl/core/ptrot_front.sv
// Front end: checks the angle, folds it onto 0..45 degrees and looks up cos/sin.
// Depends on ptrot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptrot_front #(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  wire logic signed [ptrot_pkg::ANGLE_BITS-1:0] angle,
    output logic                                         err,
    output logic signed [TRIG_FRAC_BITS+1:0]             cos_val,
    output logic signed [TRIG_FRAC_BITS+1:0]             sin_val
);
    import ptrot_pkg::*;

    localparam int TW  = TRIG_FRAC_BITS + 2;
    localparam int SHL = (TRIG_FRAC_BITS >= TABLE_FRAC) ? TRIG_FRAC_BITS - TABLE_FRAC : 0;
    localparam int SHR = (TRIG_FRAC_BITS < TABLE_FRAC) ? TABLE_FRAC - TRIG_FRAC_BITS : 0;
    localparam logic [31:0] RND = (SHR > 0) ? (32'd1 << (SHR - 1)) : 32'd0;

    fold_t                 fold;
    logic [FOLD_BITS-1:0]  a0;
    logic [FOLD_BITS-1:0]  a1;
    logic [FOLD_BITS-1:0]  a2;
    logic [FOLD_BITS-1:0]  a3;
    logic [31:0]           c_wide;
    logic [31:0]           s_wide;
    logic signed [TW-1:0]  c_tab;
    logic signed [TW-1:0]  s_tab;
    logic signed [TW-1:0]  c_sw;
    logic signed [TW-1:0]  s_sw;

    always_comb
    begin
        fold.err   = angle[ANGLE_BITS-1] | (angle > ANGLE_LAST);
        a0         = angle[FOLD_BITS-1:0];
        fold.neg_s = (a0 > ANG_180);
        a1         = fold.neg_s ? (ANG_360 - a0) : a0;
        fold.neg_c = (a1 > ANG_90);
        a2         = fold.neg_c ? (ANG_180 - a1) : a1;
        fold.swap  = (a2 > ANG_45);
        a3         = fold.swap ? (ANG_90 - a2) : a2;
        fold.idx   = a3[INDEX_BITS-1:0];

        // rescale Q1.14 table to the working fraction, rounding half up when narrowing
        c_wide = ((32'(cos_q14(fold.idx)) << SHL) + RND) >> SHR;
        s_wide = ((32'(sin_q14(fold.idx)) << SHL) + RND) >> SHR;
        c_tab  = c_wide[TW-1:0];
        s_tab  = s_wide[TW-1:0];

        c_sw    = fold.swap ? s_tab : c_tab;
        s_sw    = fold.swap ? c_tab : s_tab;
        cos_val = fold.neg_c ? -c_sw : c_sw;
        sin_val = fold.neg_s ? -s_sw : s_sw;
        err     = fold.err;
    end

endmodule

`default_nettype wire

FILE: rtl/core/ptrot_queue.sv
// Two-word queue between the front end and the rotation pipeline.
// Depends on ptrot_pkg only by convention; holds packed words of any width.
`timescale 1ns / 1ps
`default_nettype none

module ptrot_queue #(
    parameter int WIDTH = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    output logic                  pop_valid,
    output logic [WIDTH-1:0]      pop_data
);
    import ptrot_pkg::*;

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             pop;

    // the pipeline behind never stalls: drain a word every cycle one is present
    assign pop       = (count_reg != 2'd0);
    assign pop_valid = pop;
    assign pop_data  = mem[rd_ptr_reg];
    assign full      = (count_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ptrot_back.sv
// Rotation pipeline: four products, two sums, truncation toward zero, output register.
// Depends on ptrot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptrot_back #(
    parameter int COORD_BITS     = 11,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_err,
    input  wire logic signed [TRIG_FRAC_BITS+1:0] in_cos,
    input  wire logic signed [TRIG_FRAC_BITS+1:0] in_sin,
    input  wire logic signed [COORD_BITS-1:0]   in_x,
    input  wire logic signed [COORD_BITS-1:0]   in_y,
    output logic                                done,
    output logic signed [COORD_BITS:0]          x_out,
    output logic signed [COORD_BITS:0]          y_out,
    output logic                                angle_error
);
    import ptrot_pkg::*;

    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int PW = TW + COORD_BITS;
    localparam int SW = PW + 1;
    localparam int OW = COORD_BITS + 1;
    localparam logic signed [SW-1:0] BIAS = SW'((64'd1 << TRIG_FRAC_BITS) - 64'd1);

    // stage 1: products
    logic                   v1_reg;
    logic                   err1_reg;
    logic signed [COORD_BITS-1:0] x1_reg;
    logic signed [COORD_BITS-1:0] y1_reg;
    logic signed [PW-1:0]   cx_reg;
    logic signed [PW-1:0]   sy_reg;
    logic signed [PW-1:0]   sx_reg;
    logic signed [PW-1:0]   cy_reg;

    // stage 2: sums
    logic                   v2_reg;
    logic                   err2_reg;
    logic signed [COORD_BITS-1:0] x2_reg;
    logic signed [COORD_BITS-1:0] y2_reg;
    logic signed [SW-1:0]   rx_reg;
    logic signed [SW-1:0]   ry_reg;

    // stage 3: output
    logic                   done_reg;
    logic                   err3_reg;
    logic signed [OW-1:0]   xo_reg;
    logic signed [OW-1:0]   yo_reg;

    logic signed [SW-1:0]   rx_bias;
    logic signed [SW-1:0]   ry_bias;
    logic signed [SW-1:0]   rx_shift;
    logic signed [SW-1:0]   ry_shift;
    logic signed [OW-1:0]   xo_next;
    logic signed [OW-1:0]   yo_next;

    always_comb
    begin
        // truncate toward zero: bias negative sums before the arithmetic shift
        rx_bias  = rx_reg + (rx_reg[SW-1] ? BIAS : SW'(0));
        ry_bias  = ry_reg + (ry_reg[SW-1] ? BIAS : SW'(0));
        rx_shift = rx_bias >>> TRIG_FRAC_BITS;
        ry_shift = ry_bias >>> TRIG_FRAC_BITS;
        if (err2_reg)
        begin
            xo_next = {x2_reg[COORD_BITS-1], x2_reg};
            yo_next = {y2_reg[COORD_BITS-1], y2_reg};
        end
        else
        begin
            xo_next = rx_shift[OW-1:0];
            yo_next = ry_shift[OW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        err1_reg <= in_err;
        x1_reg   <= in_x;
        y1_reg   <= in_y;
        cx_reg   <= PW'(in_cos) * PW'(in_x);
        sy_reg   <= PW'(in_sin) * PW'(in_y);
        sx_reg   <= PW'(in_sin) * PW'(in_x);
        cy_reg   <= PW'(in_cos) * PW'(in_y);

        err2_reg <= err1_reg;
        x2_reg   <= x1_reg;
        y2_reg   <= y1_reg;
        rx_reg   <= SW'(cx_reg) - SW'(sy_reg);
        ry_reg   <= SW'(sx_reg) + SW'(cy_reg);

        err3_reg <= err2_reg;
        xo_reg   <= xo_next;
        yo_reg   <= yo_next;
    end

    assign done        = done_reg;
    assign x_out       = xo_reg;
    assign y_out       = yo_reg;
    assign angle_error = err3_reg;

endmodule

`default_nettype wire
